// File: rtl/rdcm_pkg.sv
package rdcm_pkg;

   localparam int unsigned CMD_W      = 2;
   localparam int unsigned WIDTH_W    = 15;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned THROTTLE_W = 13;
   localparam int unsigned STEER_W    = 8;
   localparam int unsigned MAG_W      = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_MODE = 2'd0,
      CMD_AUX  = 2'd1,
      CMD_PAIR = 2'd2,
      CMD_BYTE = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      PH_START  = 4'b0001,
      PH_SIGN   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   // pulse widths, us
   localparam logic [WIDTH_W-1:0] MID_US        = 15'd1500;
   localparam logic [WIDTH_W-1:0] MAX_WIDTH_US  = 15'd25000;
   localparam logic [WIDTH_W-1:0] STEER_BASE_US = 15'd1000;
   localparam logic [WIDTH_W-1:0] STEER_SPAN_US = 15'd1000;

   // throttle commands, us
   localparam logic [THROTTLE_W-1:0] THR_MID      = 13'd1500;
   localparam logic [THROTTLE_W-1:0] THR_REVERSE  = 13'd1450;
   localparam logic [THROTTLE_W-1:0] THR_TURN     = 13'd1553;
   localparam logic [THROTTLE_W-1:0] THR_STRAIGHT = 13'd1555;

   // steering angles, degrees
   localparam logic [STEER_W-1:0] STEER_MIN        = 8'd40;
   localparam logic [STEER_W-1:0] STEER_MAX        = 8'd140;
   localparam logic [STEER_W-1:0] STEER_CENTER     = 8'd90;
   localparam logic [STEER_W-1:0] RED_ABOVE        = 8'd93;
   localparam logic [STEER_W-1:0] MAN_BLUE_BELOW   = 8'd80;
   localparam logic [STEER_W-1:0] AUTO_BLUE_BELOW  = 8'd83;
   localparam logic [STEER_W-1:0] TURN_LOW         = 8'd60;
   localparam logic [STEER_W-1:0] TURN_HIGH        = 8'd120;

   localparam logic [MAG_W-1:0] SAT_MAG    = 7'd127;
   localparam logic [MAG_W-1:0] LINE_CLAMP = 7'd50;

   // x/5 = (x*52429)>>18 exact below 2^18; x/10 = (x*205)>>11 exact below 1024
   localparam logic [16:0] DIV5_MUL   = 17'd52429;
   localparam int unsigned DIV5_SHIFT = 18;
   localparam logic [7:0]  DIV10_MUL   = 8'd205;
   localparam int unsigned DIV10_SHIFT = 11;

   // ASCII
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
   localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

endpackage

// File: rtl/rdcm_channels.sv
interface rdcm_req_if;
   logic                              valid;
   logic                              ready;
   logic [rdcm_pkg::CMD_W-1:0]        cmd;
   logic [rdcm_pkg::WIDTH_W-1:0]      pulse_width;
   logic [rdcm_pkg::WIDTH_W-1:0]      steer_width;
   logic [rdcm_pkg::BYTE_W-1:0]       serial_byte;

   modport source (output valid, cmd, pulse_width, steer_width, serial_byte, input ready);
   modport sink   (input valid, cmd, pulse_width, steer_width, serial_byte, output ready);
endinterface

interface rdcm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rdcm_pkg::THROTTLE_W-1:0]   throttle_us;
   logic [rdcm_pkg::STEER_W-1:0]      steer_deg;
   logic                              aux_on;
   logic                              led_red;
   logic                              blue_led;
   logic                              serial_mode;

   modport source (output valid, throttle_us, steer_deg, aux_on, led_red, blue_led, serial_mode,
                   input ready);
   modport sink   (input valid, throttle_us, steer_deg, aux_on, led_red, blue_led, serial_mode,
                   output ready);
endinterface

// File: rtl/rc_drive_command_mixer.sv
// RC drive command mixer. Each request transaction is one event (mode pulse, aux pulse,
// manual throttle/steer pair, or serial byte) and produces exactly one response
// transaction carrying the throttle, steering angle, aux, LED and mode outputs as they
// stand after the event. The block takes one transaction per cycle unless response
// backpressure stalls it: a request is captured in an input register, evaluated
// combinationally, and the updated control state is itself the response register, so a
// response is offered once its request has passed both registers; response backpressure
// stalls the input register, with one request held while a response waits.
module rc_drive_command_mixer (
   input  logic       clock,
   input  logic       reset,
   rdcm_req_if.sink   req_chan,
   rdcm_rsp_if.source rsp_chan
);

   // input register
   logic                                in_valid_ff;
   logic [rdcm_pkg::CMD_W-1:0]          cmd_ff;
   logic [rdcm_pkg::WIDTH_W-1:0]        pw_ff;
   logic [rdcm_pkg::WIDTH_W-1:0]        sw_ff;
   logic [rdcm_pkg::BYTE_W-1:0]         byte_ff;

   // control state, also the response payload
   logic                                rsp_valid_ff;
   logic                                auto_ff, auto_in;
   logic                                aux_ff, aux_in;
   logic [rdcm_pkg::THROTTLE_W-1:0]     throttle_ff, throttle_us_in;
   logic [rdcm_pkg::STEER_W-1:0]        steer_ff, steer_deg_in;
   logic                                red_ff, red_in;
   logic                                blue_ff, blue_in;
   rdcm_pkg::phase_type                 phase_ff, phase_in;
   logic                                neg_ff, neg_in;
   logic [rdcm_pkg::MAG_W-1:0]          mag_ff, mag_in;

   logic advance;
   logic take_req;

   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign take_req = req_chan.valid && req_chan.ready;

   assign req_chan.ready       = !in_valid_ff || advance;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.throttle_us = throttle_ff;
   assign rsp_chan.steer_deg   = steer_ff;
   assign rsp_chan.aux_on      = aux_ff;
   assign rsp_chan.led_red     = red_ff;
   assign rsp_chan.blue_led    = blue_ff;
   assign rsp_chan.serial_mode = auto_ff;

   // manual pair mapping
   logic [rdcm_pkg::WIDTH_W-1:0]    w_c, s_c, thr_diff, st_diff;
   logic                            thr_up;
   logic [31:0]                     div5_prod;
   logic [rdcm_pkg::THROTTLE_W-1:0] thr_q;
   logic [rdcm_pkg::THROTTLE_W-1:0] man_thr;
   logic [17:0]                     div10_prod;
   logic [rdcm_pkg::STEER_W-1:0]    man_steer;

   assign w_c = (pw_ff > rdcm_pkg::MAX_WIDTH_US) ? '0 : pw_ff;
   assign s_c = (sw_ff > rdcm_pkg::MAX_WIDTH_US) ? '0 : sw_ff;

   assign thr_up    = w_c > rdcm_pkg::MID_US;
   assign thr_diff  = thr_up ? (w_c - rdcm_pkg::MID_US) : (rdcm_pkg::MID_US - w_c);
   assign div5_prod = 32'(thr_diff) * 32'(rdcm_pkg::DIV5_MUL);
   assign thr_q     = div5_prod[rdcm_pkg::DIV5_SHIFT +: rdcm_pkg::THROTTLE_W];
   assign man_thr   = thr_up ? (rdcm_pkg::THR_MID + thr_q) : (rdcm_pkg::THR_MID - thr_q);

   assign st_diff    = s_c - rdcm_pkg::STEER_BASE_US;
   assign div10_prod = 18'(st_diff[9:0]) * 18'(rdcm_pkg::DIV10_MUL);

   always_comb begin
      if (s_c <= rdcm_pkg::STEER_BASE_US) begin
         man_steer = rdcm_pkg::STEER_MIN;
      end else if (st_diff >= rdcm_pkg::STEER_SPAN_US) begin
         man_steer = rdcm_pkg::STEER_MAX;
      end else begin
         man_steer = rdcm_pkg::STEER_MIN
                   + {1'b0, div10_prod[rdcm_pkg::DIV10_SHIFT +: 7]};
      end
   end

   // serial parsing
   logic                             is_digit, is_space, is_sign;
   logic [3:0]                       digit_val;
   logic [10:0]                      mag_acc;
   logic [rdcm_pkg::MAG_W-1:0]       mag_sat;
   logic [rdcm_pkg::MAG_W-1:0]       mag_cl;
   logic [rdcm_pkg::STEER_W-1:0]     line_steer;

   assign is_digit  = (byte_ff >= rdcm_pkg::CH_ZERO) && (byte_ff <= rdcm_pkg::CH_NINE);
   assign is_space  = (byte_ff == rdcm_pkg::CH_SPACE) || (byte_ff == rdcm_pkg::CH_TAB) ||
                      (byte_ff == rdcm_pkg::CH_VT) || (byte_ff == rdcm_pkg::CH_FF) ||
                      (byte_ff == rdcm_pkg::CH_CR);
   assign is_sign   = (byte_ff == rdcm_pkg::CH_PLUS) || (byte_ff == rdcm_pkg::CH_MINUS);
   assign digit_val = byte_ff[3:0];
   assign mag_acc   = 11'(mag_ff) * 11'd10 + 11'(digit_val);
   assign mag_sat   = (mag_acc > 11'(rdcm_pkg::SAT_MAG)) ? rdcm_pkg::SAT_MAG
                                                         : mag_acc[rdcm_pkg::MAG_W-1:0];
   assign mag_cl    = (mag_ff > rdcm_pkg::LINE_CLAMP) ? rdcm_pkg::LINE_CLAMP : mag_ff;
   assign line_steer = neg_ff ? (rdcm_pkg::STEER_CENTER - {1'b0, mag_cl})
                              : (rdcm_pkg::STEER_CENTER + {1'b0, mag_cl});

   always_comb begin
      auto_in        = auto_ff;
      aux_in         = aux_ff;
      throttle_us_in = throttle_ff;
      steer_deg_in   = steer_ff;
      red_in         = red_ff;
      blue_in        = blue_ff;
      phase_in       = phase_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      case (rdcm_pkg::cmd_type'(cmd_ff))
         rdcm_pkg::CMD_MODE: begin
            auto_in = pw_ff > rdcm_pkg::MID_US;
         end
         rdcm_pkg::CMD_AUX: begin
            aux_in = pw_ff > rdcm_pkg::MID_US;
         end
         rdcm_pkg::CMD_PAIR: begin
            if (!auto_ff) begin
               throttle_us_in = man_thr;
               steer_deg_in   = man_steer;
               if (man_thr < rdcm_pkg::THR_REVERSE) begin
                  red_in  = 1'b1;
                  blue_in = 1'b1;
               end else begin
                  red_in  = man_steer > rdcm_pkg::RED_ABOVE;
                  blue_in = man_steer < rdcm_pkg::MAN_BLUE_BELOW;
               end
            end
         end
         rdcm_pkg::CMD_BYTE: begin
            if (auto_ff) begin
               if (byte_ff == rdcm_pkg::CH_LF) begin
                  steer_deg_in   = line_steer;
                  throttle_us_in = (line_steer < rdcm_pkg::TURN_LOW ||
                                    line_steer > rdcm_pkg::TURN_HIGH) ? rdcm_pkg::THR_TURN
                                                                      : rdcm_pkg::THR_STRAIGHT;
                  red_in         = line_steer > rdcm_pkg::RED_ABOVE;
                  blue_in        = line_steer < rdcm_pkg::AUTO_BLUE_BELOW;
                  phase_in       = rdcm_pkg::PH_START;
                  neg_in         = 1'b0;
                  mag_in         = '0;
               end else begin
                  case (phase_ff)
                     rdcm_pkg::PH_START: begin
                        if (is_space) begin
                           phase_in = rdcm_pkg::PH_START;
                        end else if (is_sign) begin
                           neg_in   = byte_ff == rdcm_pkg::CH_MINUS;
                           phase_in = rdcm_pkg::PH_SIGN;
                        end else if (is_digit) begin
                           mag_in   = {3'b000, digit_val};
                           phase_in = rdcm_pkg::PH_DIGITS;
                        end else begin
                           phase_in = rdcm_pkg::PH_DONE;
                        end
                     end
                     rdcm_pkg::PH_SIGN, rdcm_pkg::PH_DIGITS: begin
                        if (is_digit) begin
                           mag_in   = mag_sat;
                           phase_in = rdcm_pkg::PH_DIGITS;
                        end else begin
                           phase_in = rdcm_pkg::PH_DONE;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
         end
         default: begin
            auto_in = auto_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         cmd_ff  <= req_chan.cmd;
         pw_ff   <= req_chan.pulse_width;
         sw_ff   <= req_chan.steer_width;
         byte_ff <= req_chan.serial_byte;
      end
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         auto_ff      <= 1'b0;
         aux_ff       <= 1'b0;
         throttle_ff  <= rdcm_pkg::THR_MID;
         steer_ff     <= rdcm_pkg::STEER_CENTER;
         red_ff       <= 1'b0;
         blue_ff      <= 1'b0;
         phase_ff     <= rdcm_pkg::PH_START;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
      end else begin
         if (take_req) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            auto_ff      <= auto_in;
            aux_ff       <= aux_in;
            throttle_ff  <= throttle_us_in;
            steer_ff     <= steer_deg_in;
            red_ff       <= red_in;
            blue_ff      <= blue_in;
            phase_ff     <= phase_in;
            neg_ff       <= neg_in;
            mag_ff       <= mag_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// File: verif/tb_rc_drive_command_mixer.sv
module tb_rc_drive_command_mixer;

   typedef struct {
      rdcm_pkg::cmd_type                 cmd;
      logic [rdcm_pkg::WIDTH_W-1:0]      pulse_width;
      logic [rdcm_pkg::WIDTH_W-1:0]      steer_width;
      logic [rdcm_pkg::BYTE_W-1:0]       serial_byte;
      int                                gap;
      bit                                drain;
   } drive_event_type;

   typedef struct packed {
      logic [rdcm_pkg::THROTTLE_W-1:0] throttle_us;
      logic [rdcm_pkg::STEER_W-1:0]    steer_deg;
      logic                            aux_on;
      logic                            led_red;
      logic                            blue_led;
      logic                            serial_mode;
   } mixer_out_type;

   logic clock;
   logic reset;

   rdcm_req_if req_chan();
   rdcm_rsp_if rsp_chan();

   rc_drive_command_mixer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   drive_event_type pending_events[$];
   mixer_out_type   expected_outputs[$];
   drive_event_type offered;
   bit              req_done;
   bit              rsp_taken;
   int              idle_left;
   int              hold_left;
   int              rsp_count;
   int              mismatch_count;
   int              cmd_count[4];
   int              line_count;

   // predicted block state
   bit                  st_auto;
   bit                  st_aux;
   int                  st_throttle;
   int                  st_steer;
   bit                  st_red;
   bit                  st_blue;
   rdcm_pkg::phase_type st_phase;
   bit                  st_neg;
   int                  st_mag;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400000;
      $display("tb_rc_drive_command_mixer failed");
      $finish;
   end

   function automatic mixer_out_type mix_event(drive_event_type ev);
      int            w;
      int            s;
      int            thr;
      int            ang;
      int            mag;
      int            m;
      logic [7:0]    c;
      bit            digit;
      bit            blank;
      mixer_out_type r;
      c = ev.serial_byte;
      digit = (c >= rdcm_pkg::CH_ZERO) && (c <= rdcm_pkg::CH_NINE);
      blank = (c == rdcm_pkg::CH_SPACE) || (c == rdcm_pkg::CH_TAB) || (c == rdcm_pkg::CH_VT) ||
              (c == rdcm_pkg::CH_FF) || (c == rdcm_pkg::CH_CR);
      case (ev.cmd)
         rdcm_pkg::CMD_MODE: st_auto = (ev.pulse_width > rdcm_pkg::MID_US);
         rdcm_pkg::CMD_AUX:  st_aux = (ev.pulse_width > rdcm_pkg::MID_US);
         rdcm_pkg::CMD_PAIR: if (!st_auto) begin
            w = (ev.pulse_width > rdcm_pkg::MAX_WIDTH_US) ? 0 : int'(ev.pulse_width);
            s = (ev.steer_width > rdcm_pkg::MAX_WIDTH_US) ? 0 : int'(ev.steer_width);
            if (w > int'(rdcm_pkg::MID_US))
               thr = int'(rdcm_pkg::THR_MID) + (w - int'(rdcm_pkg::MID_US)) / 5;
            else
               thr = int'(rdcm_pkg::THR_MID) - (int'(rdcm_pkg::MID_US) - w) / 5;
            if (s <= int'(rdcm_pkg::STEER_BASE_US)) ang = int'(rdcm_pkg::STEER_MIN);
            else ang = (s - int'(rdcm_pkg::STEER_BASE_US)) / 10 + int'(rdcm_pkg::STEER_MIN);
            if (ang > int'(rdcm_pkg::STEER_MAX)) ang = int'(rdcm_pkg::STEER_MAX);
            st_throttle = thr;
            st_steer = ang;
            if (thr < int'(rdcm_pkg::THR_REVERSE)) begin
               st_red = 1'b1;
               st_blue = 1'b1;
            end else begin
               st_red = (ang > int'(rdcm_pkg::RED_ABOVE));
               st_blue = (ang < int'(rdcm_pkg::MAN_BLUE_BELOW));
            end
         end
         rdcm_pkg::CMD_BYTE: if (st_auto) begin
            if (c == rdcm_pkg::CH_LF) begin
               mag = (st_mag > int'(rdcm_pkg::LINE_CLAMP)) ? int'(rdcm_pkg::LINE_CLAMP) : st_mag;
               ang = st_neg ? int'(rdcm_pkg::STEER_CENTER) - mag
                            : int'(rdcm_pkg::STEER_CENTER) + mag;
               st_steer = ang;
               st_throttle = (ang < int'(rdcm_pkg::TURN_LOW) || ang > int'(rdcm_pkg::TURN_HIGH)) ?
                             int'(rdcm_pkg::THR_TURN) : int'(rdcm_pkg::THR_STRAIGHT);
               st_red = (ang > int'(rdcm_pkg::RED_ABOVE));
               st_blue = (ang < int'(rdcm_pkg::AUTO_BLUE_BELOW));
               st_phase = rdcm_pkg::PH_START;
               st_neg = 1'b0;
               st_mag = 0;
            end else begin
               case (st_phase)
                  rdcm_pkg::PH_START: if (!blank) begin
                     if (c == rdcm_pkg::CH_PLUS || c == rdcm_pkg::CH_MINUS) begin
                        st_neg = (c == rdcm_pkg::CH_MINUS);
                        st_phase = rdcm_pkg::PH_SIGN;
                     end else if (digit) begin
                        st_mag = int'(c - rdcm_pkg::CH_ZERO);
                        st_phase = rdcm_pkg::PH_DIGITS;
                     end else begin
                        st_phase = rdcm_pkg::PH_DONE;
                     end
                  end
                  rdcm_pkg::PH_SIGN, rdcm_pkg::PH_DIGITS: if (digit) begin
                     m = st_mag * 10 + int'(c - rdcm_pkg::CH_ZERO);
                     st_mag = (m > int'(rdcm_pkg::SAT_MAG)) ? int'(rdcm_pkg::SAT_MAG) : m;
                     st_phase = rdcm_pkg::PH_DIGITS;
                  end else begin
                     st_phase = rdcm_pkg::PH_DONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
      r.throttle_us = st_throttle[rdcm_pkg::THROTTLE_W-1:0];
      r.steer_deg   = st_steer[rdcm_pkg::STEER_W-1:0];
      r.aux_on      = st_aux;
      r.led_red     = st_red;
      r.blue_led    = st_blue;
      r.serial_mode = st_auto;
      return r;
   endfunction

   task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   task automatic add_event(rdcm_pkg::cmd_type cmd, int pw, int sw, int sb, bit drain = 1'b0);
      drive_event_type ev;
      bit              burst;
      burst = ((pending_events.size() / 40) % 4) == 3;
      ev.cmd = cmd;
      ev.pulse_width = pw[rdcm_pkg::WIDTH_W-1:0];
      ev.steer_width = sw[rdcm_pkg::WIDTH_W-1:0];
      ev.serial_byte = sb[rdcm_pkg::BYTE_W-1:0];
      ev.gap = burst ? 0 : $urandom_range(0, 3);
      ev.drain = drain;
      pending_events.push_back(ev);
   endtask

   task automatic add_byte(int sb);
      add_event(rdcm_pkg::CMD_BYTE, $urandom_range(0, 32767), $urandom_range(0, 32767), sb);
   endtask

   function automatic int pick_width();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 999);
         1: return $urandom_range(1000, 2000);
         2: return $urandom_range(2001, 25000);
         3: return $urandom_range(25001, 32767);
         4: begin
            case ($urandom_range(0, 7))
               0: return 0;
               1: return 1000;
               2: return 1001;
               3: return 1500;
               4: return 1501;
               5: return 25000;
               6: return 25001;
               default: return 32767;
            endcase
         end
         default: return $urandom_range(0, 32767);
      endcase
   endfunction

   // one serial line with random content; occasionally left open or doubled
   task automatic add_serial_line();
      int n;
      int k;
      int b;
      n = $urandom_range(0, 2);
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 4))
            0: add_byte(rdcm_pkg::CH_SPACE);
            1: add_byte(rdcm_pkg::CH_TAB);
            2: add_byte(rdcm_pkg::CH_CR);
            3: add_byte(rdcm_pkg::CH_VT);
            default: add_byte(rdcm_pkg::CH_FF);
         endcase
      end
      case ($urandom_range(0, 2))
         1: add_byte(rdcm_pkg::CH_PLUS);
         2: add_byte(rdcm_pkg::CH_MINUS);
         default: begin
         end
      endcase
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      for (k = 0; k < n; k++) add_byte(int'(rdcm_pkg::CH_ZERO) + $urandom_range(0, 9));
      if ($urandom_range(0, 9) < 3) begin
         n = $urandom_range(1, 3);
         for (k = 0; k < n; k++) begin
            b = $urandom_range(0, 255);
            if (b == int'(rdcm_pkg::CH_LF)) b = int'(rdcm_pkg::CH_ZERO);
            add_byte(b);
         end
      end
      if ($urandom_range(0, 19) != 0) add_byte(rdcm_pkg::CH_LF);
      if ($urandom_range(0, 19) == 0) add_byte(rdcm_pkg::CH_LF);
   endtask

   task automatic build_stimulus();
      int  counted;
      bit  gen_auto;
      bit  next_drain;
      int  pick;
      // idle state, aux switching
      add_event(rdcm_pkg::CMD_AUX, 0, 0, 0);
      add_event(rdcm_pkg::CMD_AUX, 1501, 32767, 255);
      add_event(rdcm_pkg::CMD_MODE, 1500, 0, 0, 1'b1);
      // manual pairs: extremes, timeout, reverse and LED thresholds
      add_event(rdcm_pkg::CMD_PAIR, 0, 0, 0);
      add_event(rdcm_pkg::CMD_PAIR, 25000, 25000, 0);
      add_event(rdcm_pkg::CMD_PAIR, 25001, 32767, 0);
      add_event(rdcm_pkg::CMD_PAIR, 1245, 1540, 0);
      add_event(rdcm_pkg::CMD_PAIR, 1250, 1530, 0);
      add_event(rdcm_pkg::CMD_PAIR, 1501, 1390, 0);
      add_event(rdcm_pkg::CMD_PAIR, 1499, 1400, 0);
      // byte dropped in manual mode
      add_byte(rdcm_pkg::CH_NINE);
      add_event(rdcm_pkg::CMD_MODE, 32767, 0, 0);
      // pair ignored in auto mode
      add_event(rdcm_pkg::CMD_PAIR, 2000, 2000, 0);
      // white space, sign, saturation and clamp
      add_byte(rdcm_pkg::CH_CR);
      add_byte(rdcm_pkg::CH_VT);
      add_byte(rdcm_pkg::CH_FF);
      add_byte(rdcm_pkg::CH_SPACE);
      add_byte(rdcm_pkg::CH_TAB);
      add_byte(rdcm_pkg::CH_MINUS);
      add_byte(rdcm_pkg::CH_NINE);
      add_byte(rdcm_pkg::CH_NINE);
      add_byte(rdcm_pkg::CH_NINE);
      add_byte(rdcm_pkg::CH_LF);
      add_byte(rdcm_pkg::CH_LF);
      add_byte(rdcm_pkg::CH_PLUS);
      add_byte(0);
      add_byte(rdcm_pkg::CH_LF);
      // partial line survives a mode round trip
      add_byte(int'(rdcm_pkg::CH_ZERO) + 3);
      add_event(rdcm_pkg::CMD_MODE, 0, 0, 0);
      add_event(rdcm_pkg::CMD_MODE, 1501, 0, 0);
      add_byte(rdcm_pkg::CH_ZERO);
      add_byte(rdcm_pkg::CH_LF);

      gen_auto = 1'b1;
      counted = 0;
      next_drain = 1'b1;
      while (counted < 450) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            gen_auto = ($urandom_range(0, 9) < 6);
            add_event(rdcm_pkg::CMD_MODE,
                      gen_auto ? $urandom_range(1501, 32767) : $urandom_range(0, 1500),
                      $urandom_range(0, 32767), $urandom_range(0, 255), next_drain);
            next_drain = 1'b0;
            counted++;
         end else if (pick < 11) begin
            add_event(rdcm_pkg::CMD_AUX, pick_width(), $urandom_range(0, 32767),
                      $urandom_range(0, 255));
            counted++;
         end else if (!gen_auto) begin
            if (pick < 90) begin
               add_event(rdcm_pkg::CMD_PAIR, pick_width(), pick_width(), $urandom_range(0, 255));
            end else begin
               add_byte($urandom_range(0, 255));
            end
            counted++;
         end else begin
            if (pick < 80) begin
               n_before_line: begin
                  int prior_size;
                  prior_size = pending_events.size();
                  add_serial_line();
                  counted += pending_events.size() - prior_size;
               end
            end else if (pick < 92) begin
               add_byte($urandom_range(0, 255));
               counted++;
            end else begin
               add_event(rdcm_pkg::CMD_PAIR, pick_width(), pick_width(), $urandom_range(0, 255));
               counted++;
            end
         end
         if (counted > 250 && counted < 260) next_drain = 1'b1;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cmd = rdcm_pkg::CMD_MODE;
      req_chan.pulse_width = '0;
      req_chan.steer_width = '0;
      req_chan.serial_byte = '0;
      rsp_chan.ready = 1'b0;
      req_done = 1'b0;
      rsp_taken = 1'b0;
      idle_left = 0;
      hold_left = 0;
      rsp_count = 0;
      mismatch_count = 0;
      line_count = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
      st_auto = 1'b0;
      st_aux = 1'b0;
      st_throttle = int'(rdcm_pkg::THR_MID);
      st_steer = int'(rdcm_pkg::STEER_CENTER);
      st_red = 1'b0;
      st_blue = 1'b0;
      st_phase = rdcm_pkg::PH_START;
      st_neg = 1'b0;
      st_mag = 0;
      build_stimulus();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_events.size() != 0 || req_chan.valid) @(posedge clock);
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_outputs.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_outputs.size());
         mismatch_count++;
      end
      $display("covered %0d mode, %0d aux, %0d pair and %0d serial transactions",
               cmd_count[rdcm_pkg::CMD_MODE], cmd_count[rdcm_pkg::CMD_AUX],
               cmd_count[rdcm_pkg::CMD_PAIR], cmd_count[rdcm_pkg::CMD_BYTE]);
      $display("%0d serial lines ended, %0d results checked", line_count, rsp_count);
      if (mismatch_count == 0) begin
         $display("tb_rc_drive_command_mixer passed");
      end else begin
         $display("tb_rc_drive_command_mixer failed");
      end
      $finish;
   end

   // sample both channels
   always @(posedge clock) begin
      mixer_out_type exp_out;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_taken = 1'b1;
            if (expected_outputs.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %0d/%0d", $time,
                        rsp_chan.throttle_us, rsp_chan.steer_deg);
               mismatch_count++;
            end else begin
               exp_out = expected_outputs.pop_front();
               check_field("throttle_us", exp_out.throttle_us, rsp_chan.throttle_us);
               check_field("steer_deg", exp_out.steer_deg, rsp_chan.steer_deg);
               check_field("aux_on", exp_out.aux_on, rsp_chan.aux_on);
               check_field("led_red", exp_out.led_red, rsp_chan.led_red);
               check_field("blue_led", exp_out.blue_led, rsp_chan.blue_led);
               check_field("serial_mode", exp_out.serial_mode, rsp_chan.serial_mode);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            req_done = 1'b1;
            cmd_count[offered.cmd]++;
            if (offered.cmd == rdcm_pkg::CMD_BYTE && st_auto &&
                offered.serial_byte == rdcm_pkg::CH_LF) line_count++;
            expected_outputs.push_back(mix_event(offered));
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_done) begin
         req_done = 1'b0;
         if (pending_events.size() != 0 && idle_left == 0 &&
             (!pending_events[0].drain || expected_outputs.size() == 0)) begin
            offered = pending_events.pop_front();
            idle_left = offered.gap;
            req_chan.valid <= 1'b1;
            req_chan.cmd <= offered.cmd;
            req_chan.pulse_width <= offered.pulse_width;
            req_chan.steer_width <= offered.steer_width;
            req_chan.serial_byte <= offered.serial_byte;
         end else begin
            req_chan.valid <= 1'b0;
            if (idle_left > 0) idle_left--;
         end
      end
   end

   // response ready, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_count++;
            if (rsp_count == 150) hold_left = 60;
            else if (((rsp_count / 50) % 4) == 1) hold_left = 0;
            else hold_left = $urandom_range(0, 3);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

endmodule
